// File: rtl/core/rpc_pkg.sv
// ============================================================================
// rpc_pkg
// Shared types, constants and CORDIC table functions for the converter.
// ============================================================================
package rpc_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 16;
    localparam int GUARD         = 24;

    localparam logic [1:0] OP_RECT  = 2'd0;
    localparam logic [1:0] OP_POLAR = 2'd1;
    localparam logic [1:0] OP_BAD_A = 2'd2;
    localparam logic [1:0] OP_BAD_B = 2'd3;

    localparam logic [63:0] PI4_Q62      = 64'h3243F6A8885A308D;
    localparam logic [63:0] INVK_INF_Q32 = 64'h00000000_9B74EDA8;

    // per-word control carried along the cell chain
    typedef struct packed {
        logic        polar;
        logic        bad;
        logic        neg;
        logic        zero;
        logic [31:0] x_in;
        logic [31:0] y_in;
        logic [32:0] mag_in;
        logic [31:0] ang;
    } t_ctrl;

    // atan(2^-i) in Q30
    function automatic logic signed [31:0] atan_q30(input int i);
        logic [63:0] q62;
        logic signed [63:0] sum;
        logic [63:0] term;
        logic plus;
        q62  = '0;
        sum  = '0;
        term = '0;
        plus = 1'b1;
        if (i == 0) begin
            q62 = PI4_Q62;
        end else begin
            for (int k = 1; k * i <= 62; k += 2) begin
                term = (64'd1 << (62 - k * i)) / 64'(k);
                sum  = plus ? sum + $signed(term) : sum - $signed(term);
                plus = !plus;
            end
            q62 = 64'(sum);
        end
        atan_q30 = 32'((q62 + 64'h80000000) >> 32);
    endfunction

    function automatic logic signed [31:0] inv_gain_q30(input int stages);
        logic [63:0] corr;
        corr = '0;
        if (2 * stages < 63) begin
            corr = ((INVK_INF_Q32 * 64'd2) / 64'd3) >> (2 * stages);
        end
        inv_gain_q30 = 32'((INVK_INF_Q32 + corr + 64'd2) >> 2);
    endfunction

endpackage

// File: rtl/core/rect_polar_converter_core.sv
// ============================================================================
// rect_polar_converter_core
// Rectangular/polar converter built from a chain of CORDIC cells.
// ============================================================================
// channel | direction | handshake        | payload
// in      | input     | i_valid/o_ready  | i_opcode, i_first_value, i_second_value
// out     | output    | o_valid/i_ready  | o_x_out, o_y_out, o_magnitude, o_angle_rad,
//         |           |                  | o_mode_out, o_bad_mode
// One word per cycle while not stalled; 3 prep stages, one per cell, 3 post.
// The whole chain advances together when the last stage is empty or taken,
// so o_ready only drops while a result is held.
// Synchronous active-low reset clears all valid bits.
module rect_polar_converter_core #(
    parameter int CORDIC_STAGES = rpc_pkg::CORDIC_STAGES,
    parameter int FRAC_BITS     = rpc_pkg::FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_opcode,
    input  logic signed [31:0]   i_first_value,
    input  logic signed [31:0]   i_second_value,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_x_out,
    output logic signed [31:0]   o_y_out,
    output logic signed [32:0]   o_magnitude,
    output logic signed [31:0]   o_angle_rad,
    output logic                 o_mode_out,
    output logic                 o_bad_mode
);
    localparam logic signed [31:0] INV_GAIN = rpc_pkg::inv_gain_q30(CORDIC_STAGES);

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    logic               v   [CORDIC_STAGES+1];
    rpc_pkg::t_ctrl     c   [CORDIC_STAGES+1];
    logic signed [63:0] x   [CORDIC_STAGES+1];
    logic signed [63:0] y   [CORDIC_STAGES+1];
    logic signed [63:0] z   [CORDIC_STAGES+1];

    rpc_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_opcode(i_opcode), .i_first_value(i_first_value),
        .i_second_value(i_second_value), .i_inv_gain(INV_GAIN),
        .o_valid(v[0]), .o_ctrl(c[0]), .o_x(x[0]), .o_y(y[0]), .o_z(z[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        rpc_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v[g]),
            .i_ctrl(c[g]), .i_x(x[g]), .i_y(y[g]), .i_z(z[g]),
            .o_valid(v[g+1]), .o_ctrl(c[g+1]), .o_x(x[g+1]), .o_y(y[g+1]),
            .o_z(z[g+1])
        );
    end

    rpc_post #(.FRAC_BITS(FRAC_BITS)) u_post (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v[CORDIC_STAGES]),
        .i_ctrl(c[CORDIC_STAGES]), .i_x(x[CORDIC_STAGES]), .i_y(y[CORDIC_STAGES]),
        .i_z(z[CORDIC_STAGES]), .i_inv_gain(INV_GAIN),
        .o_valid(o_valid), .o_x_out(o_x_out), .o_y_out(o_y_out),
        .o_magnitude(o_magnitude), .o_angle_rad(o_angle_rad),
        .o_mode_out(o_mode_out), .o_bad_mode(o_bad_mode)
    );

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_mode |-> o_x_out == 0 && o_magnitude == 0 && !o_mode_out)
        else $error("bad opcode result not cleared");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_magnitude))
        else $error("result dropped under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("stalled with empty output");
endmodule

// File: rtl/core/rpc_cell.sv
// ============================================================================
// rpc_cell
// One CORDIC micro-rotation; vectoring or rotation chosen per word.
// ============================================================================
module rpc_cell #(
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  rpc_pkg::t_ctrl       i_ctrl,
    input  logic signed [63:0]   i_x,
    input  logic signed [63:0]   i_y,
    input  logic signed [63:0]   i_z,
    output logic                 o_valid,
    output rpc_pkg::t_ctrl       o_ctrl,
    output logic signed [63:0]   o_x,
    output logic signed [63:0]   o_y,
    output logic signed [63:0]   o_z
);
    localparam logic signed [63:0] ATAN = 64'(rpc_pkg::atan_q30(STAGE));

    logic               r_valid;
    rpc_pkg::t_ctrl     r_ctrl;
    logic signed [63:0] r_x, r_y, r_z;
    logic signed [63:0] n_x, n_y, n_z, dx, dy;
    logic               dir;

    always_comb begin
        dx  = i_y >>> STAGE;
        dy  = i_x >>> STAGE;
        // vectoring follows y, rotation follows z
        dir = i_ctrl.polar ? (i_z >= 0) : (i_y < 0);
        if (dir) begin
            n_x = i_x - dx; n_y = i_y + dy;
            n_z = i_ctrl.polar ? i_z - ATAN : i_z - ATAN;
        end else begin
            n_x = i_x + dx; n_y = i_y - dy;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_ctrl <= i_ctrl;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
endmodule

// File: rtl/core/rpc_prep.sv
// ============================================================================
// rpc_prep
// Input stage: quadrant fold, degree scaling and angle range reduction.
// ============================================================================
module rpc_prep #(
    parameter int FRAC_BITS = rpc_pkg::FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [1:0]           i_opcode,
    input  logic signed [31:0]   i_first_value,
    input  logic signed [31:0]   i_second_value,
    input  logic signed [31:0]   i_inv_gain,
    output logic                 o_valid,
    output rpc_pkg::t_ctrl       o_ctrl,
    output logic signed [63:0]   o_x,
    output logic signed [63:0]   o_y,
    output logic signed [63:0]   o_z
);
    localparam logic signed [63:0] K32   = 64'((rpc_pkg::PI4_Q62 / 64'd45) >> 30);
    localparam logic signed [63:0] PIP   = 64'(rpc_pkg::PI4_Q62 >> (28 - FRAC_BITS));
    localparam logic signed [63:0] TWOPI = PIP <<< 1;
    localparam logic signed [63:0] PI30  = 64'(rpc_pkg::PI4_Q62 >> 30);
    localparam logic signed [63:0] HALF30 = 64'(rpc_pkg::PI4_Q62 >> 31);

    // quotient bits needed so that TWOPI << QB covers the largest |p|
    function automatic int red_bits();
        logic signed [63:0] lim;
        int n;
        lim = K32 <<< 31;
        n   = 0;
        while (((TWOPI <<< n) <= lim) && (n < 60)) n++;
        return n;
    endfunction

    localparam int QB = red_bits();
    localparam int QH = QB / 2;

    // stage A: degree product registered
    logic               r_a_valid;
    logic [1:0]         r_a_op;
    logic signed [31:0] r_a_a, r_a_b;
    logic signed [63:0] r_a_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
        if (i_en) begin
            r_a_op <= i_opcode;
            r_a_a  <= i_first_value;
            r_a_b  <= i_second_value;
            r_a_p  <= 64'(i_second_value) * K32;
        end
    end

    // stage B: bias positive, upper half of the 2*pi compare-subtract steps
    logic signed [63:0] r_b_p;
    logic               r_b_valid;
    logic [1:0]         r_b_op;
    logic signed [31:0] r_b_a, r_b_b;
    logic signed [63:0] r_b_r;
    logic signed [63:0] rb;

    always_comb begin
        rb = r_a_p + (TWOPI <<< QB);
        for (int k = QB; k > QH; k--) begin
            if (rb >= (TWOPI <<< k)) rb = rb - (TWOPI <<< k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
        if (i_en) begin
            r_b_op <= r_a_op;
            r_b_a  <= r_a_a;
            r_b_b  <= r_a_b;
            r_b_p  <= r_a_p;
            r_b_r  <= rb;
        end
    end

    // stage C: finish reduction, build CORDIC start vector
    rpc_pkg::t_ctrl     n_ctrl;
    logic signed [63:0] n_x, n_y, n_z, z0, pr, xa, ya, rr;
    logic               xneg;

    always_comb begin
        n_ctrl        = '0;
        n_ctrl.x_in   = r_b_a;
        n_ctrl.y_in   = r_b_b;
        n_ctrl.mag_in = 33'(r_b_a);
        n_x = '0; n_y = '0; n_z = '0;
        rr  = r_b_r;
        for (int k = QH; k >= 0; k--) begin
            if (rr >= (TWOPI <<< k)) rr = rr - (TWOPI <<< k);
        end
        if (rr >= PIP) rr = rr - TWOPI;
        z0  = rr >>> (FRAC_BITS + 2);
        pr  = r_b_p + 64'sd2147483648;
        pr  = pr >>> 32;
        if (pr > 64'sd2147483647) pr = 64'sd2147483647;
        if (pr < -64'sd2147483648) pr = -64'sd2147483648;
        xneg = r_b_a < 0;
        xa   = xneg ? -64'(r_b_a) : 64'(r_b_a);
        ya   = xneg ? -64'(r_b_b) : 64'(r_b_b);
        case (r_b_op)
            rpc_pkg::OP_RECT: begin
                n_ctrl.zero = (r_b_a == 0) && (r_b_b == 0);
                n_x = xa <<< rpc_pkg::GUARD;
                n_y = ya <<< rpc_pkg::GUARD;
                n_z = xneg ? ((r_b_b >= 0) ? PI30 : -PI30) : 64'sd0;
            end
            rpc_pkg::OP_POLAR: begin
                n_ctrl.polar = 1'b1;
                n_ctrl.ang   = 32'(pr);
                n_x = 64'(i_inv_gain);
                if (z0 > HALF30) begin
                    n_z = z0 - PI30; n_ctrl.neg = 1'b1;
                end else if (z0 < -HALF30) begin
                    n_z = z0 + PI30; n_ctrl.neg = 1'b1;
                end else begin
                    n_z = z0;
                end
            end
            default: begin
                n_ctrl     = '0;
                n_ctrl.bad = 1'b1;
            end
        endcase
    end

    logic               r_valid;
    rpc_pkg::t_ctrl     r_ctrl;
    logic signed [63:0] r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_b_valid;
        end
        if (i_en) begin
            r_ctrl <= n_ctrl;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
endmodule

// File: rtl/core/rpc_post.sv
// ============================================================================
// rpc_post
// Output stage: gain correction, scaling, rounding and saturation.
// ============================================================================
module rpc_post #(
    parameter int FRAC_BITS = rpc_pkg::FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  rpc_pkg::t_ctrl       i_ctrl,
    input  logic signed [63:0]   i_x,
    input  logic signed [63:0]   i_y,
    input  logic signed [63:0]   i_z,
    input  logic signed [31:0]   i_inv_gain,
    output logic                 o_valid,
    output logic signed [31:0]   o_x_out,
    output logic signed [31:0]   o_y_out,
    output logic signed [32:0]   o_magnitude,
    output logic signed [31:0]   o_angle_rad,
    output logic                 o_mode_out,
    output logic                 o_bad_mode
);
    localparam int SH = rpc_pkg::GUARD + 30;

    // stage 1: fold sign, clamp a negative rectangular x to zero
    logic               r1_valid;
    rpc_pkg::t_ctrl     r1_ctrl;
    logic signed [63:0] r1_x, r1_y, r1_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_ctrl <= i_ctrl;
            r1_x    <= (i_ctrl.neg) ? -i_x : ((!i_ctrl.polar && i_x < 0) ? 64'sd0 : i_x);
            r1_y    <= (i_ctrl.neg) ? -i_y : i_y;
            r1_z    <= i_z;
        end
    end

    // stage 2: products, x split into 32-bit halves for the gain partial products
    logic               r2_valid;
    rpc_pkg::t_ctrl     r2_ctrl;
    logic [63:0]        r2_p0, r2_p1;
    logic signed [63:0] r2_mx, r2_my, r2_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_ctrl <= r1_ctrl;
            r2_p0   <= 64'(r1_x[31:0]) * 64'(unsigned'(i_inv_gain));
            r2_p1   <= 64'(r1_x[63:32]) * 64'(unsigned'(i_inv_gain));
            r2_mx   <= 64'(signed'(r1_ctrl.mag_in[31:0])) * 64'(signed'(r1_x[31:0]));
            r2_my   <= 64'(signed'(r1_ctrl.mag_in[31:0])) * 64'(signed'(r1_y[31:0]));
            r2_z    <= r1_z;
        end
    end

    // stage 3: round, saturate, select
    logic [63:0]        hi, mg;
    logic signed [63:0] ax, ay, az;
    logic signed [31:0] n_x, n_y, n_a;
    logic signed [32:0] n_m;

    always_comb begin
        hi = r2_p1 + (r2_p0 >> 32) + (64'd1 << (SH - 33));
        mg = hi >> (SH - 32);
        if (mg > 64'hFFFFFFFF) mg = 64'hFFFFFFFF;
        ax = (r2_mx + 64'sd536870912) >>> 30;
        ay = (r2_my + 64'sd536870912) >>> 30;
        az = (r2_z + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (ax > 64'sd2147483647) ax = 64'sd2147483647;
        if (ax < -64'sd2147483648) ax = -64'sd2147483648;
        if (ay > 64'sd2147483647) ay = 64'sd2147483647;
        if (ay < -64'sd2147483648) ay = -64'sd2147483648;
        if (az > 64'sd2147483647) az = 64'sd2147483647;
        if (az < -64'sd2147483648) az = -64'sd2147483648;
        n_x = '0; n_y = '0; n_m = '0; n_a = '0;
        if (r2_ctrl.bad) begin
            n_x = '0;
        end else if (r2_ctrl.polar) begin
            n_x = 32'(ax);
            n_y = 32'(ay);
            n_m = r2_ctrl.mag_in;
            n_a = r2_ctrl.ang;
        end else begin
            n_x = r2_ctrl.x_in;
            n_y = r2_ctrl.y_in;
            if (!r2_ctrl.zero) begin
                n_m = 33'(mg);
                n_a = 32'(az);
            end
        end
    end

    logic               r_valid;
    logic signed [31:0] r_x, r_y, r_a;
    logic signed [32:0] r_m;
    logic               r_mode, r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r2_valid;
        end
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_m    <= n_m;
            r_a    <= n_a;
            r_mode <= r2_ctrl.polar;
            r_bad  <= r2_ctrl.bad;
        end
    end

    assign o_valid     = r_valid;
    assign o_x_out     = r_x;
    assign o_y_out     = r_y;
    assign o_magnitude = r_m;
    assign o_angle_rad = r_a;
    assign o_mode_out  = r_mode;
    assign o_bad_mode  = r_bad;
endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Checks rect_polar_converter_core against a bit-exact CORDIC predictor.
// Directed corner words, then random rectangular, polar and invalid words.
// The sender works in random bursts and the receiver stalls on its own pattern.
// ============================================================================
module testbench;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_WORDS   = 830;

    typedef struct {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [32:0] magnitude;
        logic signed [31:0] angle_rad;
        logic               mode_out;
        logic               bad_mode;
    } t_conv_result;

    class conv_scoreboard;
        t_conv_result pending_results[$];
        int           errors = 0;

        function longint sat(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint atan_step(int i);
            logic [63:0] q;
            longint      s;
            longint      t;
            bit          plus;
            s    = 0;
            plus = 1'b1;
            if (i == 0) begin
                q = rpc_pkg::PI4_Q62;
            end else begin
                for (int k = 1; k * i <= 62; k += 2) begin
                    t    = longint'((64'd1 << (62 - k * i)) / 64'(k));
                    s    = plus ? s + t : s - t;
                    plus = !plus;
                end
                q = 64'(s);
            end
            return longint'((q + 64'h80000000) >> 32);
        endfunction

        function longint cordic_gain();
            logic [63:0] c;
            logic [63:0] corr;
            c    = rpc_pkg::INVK_INF_Q32;
            corr = 0;
            if (2 * rpc_pkg::CORDIC_STAGES < 63)
                corr = (c * 64'd2 / 64'd3) >> (2 * rpc_pkg::CORDIC_STAGES);
            return longint'((c + corr + 64'd2) >> 2);
        endfunction

        function t_conv_result predict_conv(logic [1:0] op, logic signed [31:0] a,
                                            logic signed [31:0] b);
            t_conv_result r;
            longint x, y, z, dx, dy, off, pi30, half30, k32, p, pip, twopi, rem, g;
            logic [127:0] prod;
            bit neg;
            r      = '{default: '0};
            pi30   = longint'(rpc_pkg::PI4_Q62 >> 30);
            half30 = longint'(rpc_pkg::PI4_Q62 >> 31);
            g      = cordic_gain();
            if (op == rpc_pkg::OP_RECT) begin
                r.x_out = a;
                r.y_out = b;
                x = a;
                y = b;
                if (!(x == 0 && y == 0)) begin
                    z   = 0;
                    off = 0;
                    if (x < 0) begin
                        off = (y >= 0) ? pi30 : -pi30;
                        x = -x;
                        y = -y;
                    end
                    x = x <<< rpc_pkg::GUARD;
                    y = y <<< rpc_pkg::GUARD;
                    for (int i = 0; i < rpc_pkg::CORDIC_STAGES; i++) begin
                        dx = y >>> i;
                        dy = x >>> i;
                        if (y >= 0) begin
                            x += dx; y -= dy; z += atan_step(i);
                        end else begin
                            x -= dx; y += dy; z -= atan_step(i);
                        end
                    end
                    if (x < 0) x = 0;
                    prod = 128'(x) * 128'(g) + (128'd1 << (rpc_pkg::GUARD + 29));
                    prod = prod >> (rpc_pkg::GUARD + 30);
                    r.magnitude = 33'(sat(longint'(prod[63:0]), 0, 64'hFFFFFFFF));
                    r.angle_rad = 32'(sat((z + off + (64'sd1 <<< (29 - rpc_pkg::FRAC_BITS)))
                                          >>> (30 - rpc_pkg::FRAC_BITS), -(64'sd1 <<< 31),
                                          (64'sd1 <<< 31) - 1));
                end
            end else if (op == rpc_pkg::OP_POLAR) begin
                r.mode_out  = 1'b1;
                r.magnitude = 33'(longint'(a));
                k32   = longint'((rpc_pkg::PI4_Q62 / 64'd45) >> 30);
                p     = longint'(b) * k32;
                pip   = longint'(rpc_pkg::PI4_Q62 >> (28 - rpc_pkg::FRAC_BITS));
                twopi = 2 * pip;
                r.angle_rad = 32'(sat((p + (64'sd1 <<< 31)) >>> 32, -(64'sd1 <<< 31),
                                      (64'sd1 <<< 31) - 1));
                rem = p % twopi;
                if (rem < 0) rem += twopi;
                if (rem >= pip) rem -= twopi;
                z   = rem >>> (rpc_pkg::FRAC_BITS + 2);
                neg = 1'b0;
                if (z > half30) begin
                    z -= pi30; neg = 1'b1;
                end else if (z < -half30) begin
                    z += pi30; neg = 1'b1;
                end
                x = g;
                y = 0;
                for (int i = 0; i < rpc_pkg::CORDIC_STAGES; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (z >= 0) begin
                        x -= dx; y += dy; z -= atan_step(i);
                    end else begin
                        x += dx; y -= dy; z += atan_step(i);
                    end
                end
                if (neg) begin
                    x = -x; y = -y;
                end
                r.x_out = 32'(sat((longint'(a) * x + (64'sd1 <<< 29)) >>> 30,
                                  -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
                r.y_out = 32'(sat((longint'(a) * y + (64'sd1 <<< 29)) >>> 30,
                                  -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
            end else begin
                r.bad_mode = 1'b1;
            end
            return r;
        endfunction

        function void note_input(logic [1:0] op, logic signed [31:0] a, logic signed [31:0] b);
            pending_results.push_back(predict_conv(op, a, b));
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(t_conv_result got);
            t_conv_result want;
            if (pending_results.size() == 0) begin
                report("word out with nothing pending", 64'd1, 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.x_out !== want.x_out) report("x_out", got.x_out, want.x_out);
                if (got.y_out !== want.y_out) report("y_out", got.y_out, want.y_out);
                if (got.magnitude !== want.magnitude)
                    report("magnitude", got.magnitude, want.magnitude);
                if (got.angle_rad !== want.angle_rad)
                    report("angle_rad", got.angle_rad, want.angle_rad);
                if (got.mode_out !== want.mode_out)
                    report("mode_out", got.mode_out, want.mode_out);
                if (got.bad_mode !== want.bad_mode)
                    report("bad_mode", got.bad_mode, want.bad_mode);
            end
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [1:0]          i_opcode = '0;
    logic signed [31:0]  i_first_value = '0;
    logic signed [31:0]  i_second_value = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic signed [31:0]  o_x_out;
    logic signed [31:0]  o_y_out;
    logic signed [32:0]  o_magnitude;
    logic signed [31:0]  o_angle_rad;
    logic                o_mode_out;
    logic                o_bad_mode;

    conv_scoreboard sb = new();
    int idle_cycles = 0;
    int burst_left  = 0;
    int rx_cycle    = 0;
    int rx_mode     = 0;

    rect_polar_converter_core i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_opcode, .i_first_value, .i_second_value,
        .o_valid, .i_ready, .o_x_out, .o_y_out, .o_magnitude, .o_angle_rad,
        .o_mode_out, .o_bad_mode
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_conv_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_input(i_opcode, i_first_value, i_second_value);
            if (o_valid && i_ready) begin
                got = '{o_x_out, o_y_out, o_magnitude, o_angle_rad, o_mode_out, o_bad_mode};
                sb.check_result(got);
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL rect_polar_converter_core");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            2: i_ready <= ($urandom_range(0, 9) < 3);
            default: i_ready <= (rx_cycle % 9) < 6;
        endcase
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task send_word(logic [1:0] op, logic [31:0] a, logic [31:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_first_value  <= a;
        i_second_value <= b;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task drain_pipe();
        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
    endtask

    function logic [31:0] rand_value(bit polar_ang);
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
            2: return polar_ang ? 32'($signed($urandom_range(0, 1440 * 65536)) - 720 * 65536)
                                : 32'($signed($urandom_range(0, 2000)) - 1000);
            3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
            default: return 32'($signed($urandom_range(0, 200000000)) - 100000000);
        endcase
    endfunction

    initial begin
        logic [1:0] op;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(rpc_pkg::OP_RECT, 32'd0, 32'd0);
        send_word(rpc_pkg::OP_RECT, 32'd65536, 32'd0);
        send_word(rpc_pkg::OP_RECT, 32'd0, 32'd65536);
        send_word(rpc_pkg::OP_RECT, -32'sd65536, 32'd0);
        send_word(rpc_pkg::OP_RECT, -32'sd1, -32'sd1);
        send_word(rpc_pkg::OP_RECT, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_word(rpc_pkg::OP_RECT, 32'h80000000, 32'h80000000);
        send_word(rpc_pkg::OP_RECT, 32'h80000000, 32'd0);
        send_word(rpc_pkg::OP_RECT, 32'd0, 32'h80000000);
        send_word(rpc_pkg::OP_RECT, 32'h7FFFFFFF, 32'h80000000);
        send_word(rpc_pkg::OP_POLAR, 32'd65536, 32'd0);
        send_word(rpc_pkg::OP_POLAR, 32'd65536, 32'd45 << 16);
        send_word(rpc_pkg::OP_POLAR, 32'd65536, 32'd90 << 16);
        send_word(rpc_pkg::OP_POLAR, 32'd65536, 32'd180 << 16);
        send_word(rpc_pkg::OP_POLAR, 32'd65536, -(32'sd180 <<< 16));
        send_word(rpc_pkg::OP_POLAR, 32'd65536, 32'd360 << 16);
        send_word(rpc_pkg::OP_POLAR, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_word(rpc_pkg::OP_POLAR, 32'h80000000, 32'h80000000);
        send_word(rpc_pkg::OP_POLAR, -32'sd131072, 32'd30 << 16);
        send_word(rpc_pkg::OP_POLAR, 32'h7FFFFFFF, 32'd45 << 16);
        send_word(rpc_pkg::OP_BAD_A, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_word(rpc_pkg::OP_BAD_B, 32'h12345678, 32'h87654321);
        drain_pipe();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) drain_pipe();
            case ($urandom_range(0, 19))
                0, 1: op = 2'($urandom_range(rpc_pkg::OP_BAD_A, rpc_pkg::OP_BAD_B));
                2, 3, 4, 5, 6, 7, 8, 9, 10: op = rpc_pkg::OP_RECT;
                default: op = rpc_pkg::OP_POLAR;
            endcase
            send_word(op, rand_value(1'b0), rand_value(op == rpc_pkg::OP_POLAR));
        end
        i_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("PASS rect_polar_converter_core");
        end else begin
            $display("FAIL rect_polar_converter_core");
        end
        $finish;
    end

endmodule

// File: rect_polar_converter_core.f
rtl/core/rpc_pkg.sv
rtl/core/rpc_cell.sv
rtl/core/rpc_prep.sv
rtl/core/rpc_post.sv
rtl/core/rect_polar_converter_core.sv
verif/testbench.sv
